// ===== src/cea_pkg.sv =====
package cea_pkg;

   localparam int DefBlocks     = 64;
   localparam int DefDirEntries = 16;
   localparam int DefIdBits     = 8;

   localparam int FileIdW  = 8;
   localparam int StartW   = 6;
   localparam int CountW   = 7;
   localparam int StatusW  = 3;
   localparam int ReqDataW = 24;
   localparam int RspDataW = 16;

   localparam logic CMD_CREATE = 1'b0;
   localparam logic CMD_DELETE = 1'b1;

   typedef enum logic [StatusW-1:0] {
      ST_OK        = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_IN_USE    = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_DIR_FULL  = 3'd4,
      ST_RANGE     = 3'd5
   } status_type;

endpackage

// ===== src/cea_ram.sv =====
module cea_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/contiguous_extent_allocator.sv =====
// channel  direction  handshake              payload
// req      in         req_tvalid/req_tready  tuser: command; tdata: file_id, start, count
// rsp      out        rsp_tvalid/rsp_tready  tdata: status, freed_start, freed_count
//
// create does a directory scan (one entry read a cycle), then, once the checks pass,
// a read pass and a write pass over the block map port.
// delete does a directory scan, then a clear pass if the file is found.
// after reset the block map is cleared one block a cycle, with req_tready low.
// a finished item waits in the output register; rsp stall holds only the last step.
module contiguous_extent_allocator
   import cea_pkg::*;
#(
   parameter int BLOCKS      = DefBlocks,
   parameter int DIR_ENTRIES = DefDirEntries,
   parameter int ID_BITS     = DefIdBits
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,  // file_id, start_block, block_count, zero pad
   input  logic                req_tuser,  // command
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata   // status, freed_start, freed_count
);

   localparam int BlkAw = $clog2(BLOCKS);
   localparam int DirAw = $clog2(DIR_ENTRIES);
   localparam int CntW  = $clog2(BLOCKS + 1);
   localparam int SumW  = (CntW > 8) ? CntW : 8;
   localparam int DirW  = ID_BITS + StartW + CountW;

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_SCAN, S_DECIDE, S_CHECK, S_MARK, S_CLEAR, S_DONE
   } state_type;

   state_type            state_ff;
   logic                 cmd_ff;
   logic [ID_BITS-1:0]   id_ff;
   logic [StartW-1:0]    start_ff;
   logic [CountW-1:0]    count_ff;
   logic [DirAw-1:0]     scan_idx_ff;
   logic [DirAw-1:0]     pidx_ff;
   logic                 issue_ff;
   logic                 pend_ff;
   logic                 hit_ff;
   logic [DirAw-1:0]     hit_idx_ff;
   logic [StartW-1:0]    hit_start_ff;
   logic [CountW-1:0]    hit_count_ff;
   logic                 free_found_ff;
   logic [DirAw-1:0]     free_idx_ff;
   logic [BlkAw-1:0]     blk_ff;
   logic [CountW-1:0]    rem_ff;
   logic                 chk_pend_ff;
   logic [DIR_ENTRIES-1:0] valid_ff;
   status_type           status_ff;
   logic [StartW-1:0]    out_start_ff;
   logic [CountW-1:0]    out_count_ff;
   logic                 rsp_vld_ff;
   logic [RspDataW-1:0]  rsp_data_ff;

   logic                 map_we;
   logic                 map_wd;
   logic                 map_rd;
   logic                 dir_we;
   logic [DirW-1:0]      dir_wd;
   logic [DirW-1:0]      dir_rd;
   logic [ID_BITS-1:0]   rd_id;
   logic [StartW-1:0]    rd_start;
   logic [CountW-1:0]    rd_count;
   logic [SumW-1:0]      end_sum;
   logic                 range_bad;

   cea_ram #(.WIDTH(1), .DEPTH(BLOCKS), .AW(BlkAw)) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (blk_ff),
      .wr_data (map_wd),
      .rd_addr (blk_ff),
      .rd_data (map_rd)
   );

   cea_ram #(.WIDTH(DirW), .DEPTH(DIR_ENTRIES), .AW(DirAw)) u_dir (
      .clock   (clock),
      .wr_en   (dir_we),
      .wr_addr (free_idx_ff),
      .wr_data (dir_wd),
      .rd_addr (scan_idx_ff),
      .rd_data (dir_rd)
   );

   always_comb begin
      map_we = (state_ff == S_INIT) ||
               ((state_ff == S_MARK || state_ff == S_CLEAR) && rem_ff != '0);
      map_wd = (state_ff == S_MARK);
      dir_we = (state_ff == S_MARK) && rem_ff == '0;
      dir_wd = {id_ff, start_ff, count_ff};
      rd_id    = dir_rd[DirW-1 -: ID_BITS];
      rd_start = dir_rd[StartW+CountW-1 -: StartW];
      rd_count = dir_rd[CountW-1:0];
      end_sum   = SumW'(start_ff) + SumW'(count_ff);
      range_bad = end_sum > SumW'(BLOCKS);
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         blk_ff        <= '0;
         valid_ff      <= '0;
         rsp_vld_ff    <= 1'b0;
         issue_ff      <= 1'b0;
         pend_ff       <= 1'b0;
         chk_pend_ff   <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         if (rsp_vld_ff && rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
         case (state_ff)
            S_INIT: begin
               blk_ff <= blk_ff + 1'b1;
               if (blk_ff == BlkAw'(BLOCKS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  cmd_ff        <= req_tuser;
                  id_ff         <= ID_BITS'(req_tdata[FileIdW-1:0]);
                  start_ff      <= req_tdata[FileIdW +: StartW];
                  count_ff      <= req_tdata[FileIdW+StartW +: CountW];
                  scan_idx_ff   <= '0;
                  issue_ff      <= 1'b1;
                  pend_ff       <= 1'b0;
                  hit_ff        <= 1'b0;
                  free_found_ff <= 1'b0;
                  state_ff      <= S_SCAN;
               end
            end
            S_SCAN: begin
               // directory read issued one cycle, compared the next
               pend_ff <= issue_ff;
               if (issue_ff) begin
                  pidx_ff <= scan_idx_ff;
                  if (scan_idx_ff == DirAw'(DIR_ENTRIES - 1)) begin
                     issue_ff <= 1'b0;
                  end else begin
                     scan_idx_ff <= scan_idx_ff + 1'b1;
                  end
               end
               if (pend_ff) begin
                  if (valid_ff[pidx_ff] && rd_id == id_ff) begin
                     hit_ff       <= 1'b1;
                     hit_idx_ff   <= pidx_ff;
                     hit_start_ff <= rd_start;
                     hit_count_ff <= rd_count;
                     issue_ff     <= 1'b0;
                     state_ff     <= S_DECIDE;
                  end else begin
                     if (!valid_ff[pidx_ff] && !free_found_ff) begin
                        free_found_ff <= 1'b1;
                        free_idx_ff   <= pidx_ff;
                     end
                     if (!issue_ff) begin
                        state_ff <= S_DECIDE;
                     end
                  end
               end
            end
            S_DECIDE: begin
               out_start_ff <= '0;
               out_count_ff <= '0;
               chk_pend_ff  <= 1'b0;
               if (cmd_ff == CMD_DELETE) begin
                  if (!hit_ff) begin
                     status_ff <= ST_NOT_FOUND;
                     state_ff  <= S_DONE;
                  end else begin
                     blk_ff       <= BlkAw'(hit_start_ff);
                     rem_ff       <= hit_count_ff;
                     out_start_ff <= hit_start_ff;
                     out_count_ff <= hit_count_ff;
                     status_ff    <= ST_OK;
                     state_ff     <= S_CLEAR;
                  end
               end else if (hit_ff) begin
                  status_ff <= ST_DUPLICATE;
                  state_ff  <= S_DONE;
               end else if (!free_found_ff) begin
                  status_ff <= ST_DIR_FULL;
                  state_ff  <= S_DONE;
               end else if (range_bad) begin
                  status_ff <= ST_RANGE;
                  state_ff  <= S_DONE;
               end else begin
                  blk_ff   <= BlkAw'(start_ff);
                  rem_ff   <= count_ff;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               chk_pend_ff <= (rem_ff != '0);
               if (rem_ff != '0) begin
                  blk_ff <= blk_ff + 1'b1;
                  rem_ff <= rem_ff - 1'b1;
               end
               if (chk_pend_ff && map_rd) begin
                  status_ff <= ST_IN_USE;
                  state_ff  <= S_DONE;
               end else if (rem_ff == '0 && !chk_pend_ff) begin
                  // range is free, go back and mark it
                  blk_ff    <= BlkAw'(start_ff);
                  rem_ff    <= count_ff;
                  status_ff <= ST_OK;
                  state_ff  <= S_MARK;
               end
            end
            S_MARK: begin
               if (rem_ff != '0) begin
                  blk_ff <= blk_ff + 1'b1;
                  rem_ff <= rem_ff - 1'b1;
               end else begin
                  valid_ff[free_idx_ff] <= 1'b1;
                  state_ff              <= S_DONE;
               end
            end
            S_CLEAR: begin
               if (rem_ff != '0) begin
                  blk_ff <= blk_ff + 1'b1;
                  rem_ff <= rem_ff - 1'b1;
               end else begin
                  valid_ff[hit_idx_ff] <= 1'b0;
                  state_ff             <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_vld_ff || rsp_tready) begin
                  rsp_data_ff <= {out_count_ff, out_start_ff, status_ff};
                  rsp_vld_ff  <= 1'b1;
                  state_ff    <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== src/cea_checker.sv =====
module cea_checker
   import cea_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic [ReqDataW-1:0] req_tdata,
   input logic                req_tuser,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RspDataW-1:0] rsp_tdata
);

   // held item stays put while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   // block map clearing runs right after reset
   a_init_busy: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during map clear");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= ST_RANGE)
      else $error("status code out of range");

   a_freed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != ST_OK |-> rsp_tdata[15:3] == '0)
      else $error("freed extent reported on failure");

endmodule

bind contiguous_extent_allocator cea_checker u_cea_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

import cea_pkg::*;

typedef struct {
   status_type         status;
   logic [StartW-1:0]  freed_start;
   logic [CountW-1:0]  freed_count;
} alloc_reply_type;

class allocation_tracker;
   localparam int NumBlocks = DefBlocks;
   localparam int NumSlots  = DefDirEntries;

   bit                  used_blocks[NumBlocks];
   bit                  slot_used[NumSlots];
   logic [FileIdW-1:0]  slot_id[NumSlots];
   logic [StartW-1:0]   slot_start[NumSlots];
   logic [CountW-1:0]   slot_count[NumSlots];
   alloc_reply_type     expected_replies[$];
   int                  errors;

   function new();
      foreach (used_blocks[b]) used_blocks[b] = 1'b0;
      foreach (slot_used[s]) slot_used[s] = 1'b0;
      errors = 0;
   endfunction

   // applies one request to the shadow bitmap and directory
   function alloc_reply_type apply_request(logic cmd, logic [FileIdW-1:0] id,
                                           logic [StartW-1:0] first,
                                           logic [CountW-1:0] len);
      alloc_reply_type r;
      int hit;
      int slot;
      int last;
      r.status = ST_OK;
      r.freed_start = '0;
      r.freed_count = '0;
      hit = -1;
      slot = -1;
      for (int s = 0; s < NumSlots; s++) begin
         if (slot_used[s] && slot_id[s] == id && hit < 0) hit = s;
         if (!slot_used[s] && slot < 0) slot = s;
      end
      if (cmd == CMD_CREATE) begin
         last = int'(first) + int'(len);
         if (hit >= 0) begin
            r.status = ST_DUPLICATE;
         end else if (slot < 0) begin
            r.status = ST_DIR_FULL;
         end else if (last > NumBlocks) begin
            r.status = ST_RANGE;
         end else begin
            for (int b = int'(first); b < last; b++)
               if (used_blocks[b]) r.status = ST_IN_USE;
            if (r.status == ST_OK) begin
               for (int b = int'(first); b < last; b++) used_blocks[b] = 1'b1;
               slot_used[slot] = 1'b1;
               slot_id[slot] = id;
               slot_start[slot] = first;
               slot_count[slot] = len;
            end
         end
      end else if (hit < 0) begin
         r.status = ST_NOT_FOUND;
      end else begin
         last = int'(slot_start[hit]) + int'(slot_count[hit]);
         for (int b = int'(slot_start[hit]); b < last && b < NumBlocks; b++)
            used_blocks[b] = 1'b0;
         slot_used[hit] = 1'b0;
         r.freed_start = slot_start[hit];
         r.freed_count = slot_count[hit];
      end
      return r;
   endfunction

   function void note_request(logic cmd, logic [FileIdW-1:0] id,
                              logic [StartW-1:0] first, logic [CountW-1:0] len);
      expected_replies.push_back(apply_request(cmd, id, first, len));
   endfunction

   task report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      errors++;
   endtask

   task check_response(logic [RspDataW-1:0] data);
      alloc_reply_type want;
      if (expected_replies.size() == 0) begin
         report_mismatch("item with nothing outstanding", int'(data), 0);
         return;
      end
      want = expected_replies.pop_front();
      if (data[2:0] != want.status)
         report_mismatch("status", int'(data[2:0]), int'(want.status));
      if (data[8:3] != want.freed_start)
         report_mismatch("freed_start", int'(data[8:3]), int'(want.freed_start));
      if (data[15:9] != want.freed_count)
         report_mismatch("freed_count", int'(data[15:9]), int'(want.freed_count));
   endtask

   function int pending();
      return expected_replies.size();
   endfunction

   function int live_files();
      int n;
      n = 0;
      foreach (slot_used[s]) if (slot_used[s]) n++;
      return n;
   endfunction

   // assumes at least one live file
   function logic [FileIdW-1:0] random_live_id();
      int pick;
      pick = $urandom_range(0, live_files() - 1);
      foreach (slot_used[s]) begin
         if (slot_used[s]) begin
            if (pick == 0) return slot_id[s];
            pick--;
         end
      end
      return '0;
   endfunction

   function int random_free_block();
      int free_list[$];
      foreach (used_blocks[b]) if (!used_blocks[b]) free_list.push_back(b);
      if (free_list.size() == 0) return -1;
      return free_list[$urandom_range(0, free_list.size() - 1)];
   endfunction
endclass

module testbench;
   localparam int unsigned CycleLimit = 1000000;
   localparam int RandomPerPhase = 300;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;   // file_id, start_block, block_count, zero pad
   logic                req_tuser = 1'b0; // command
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;        // status, freed_start, freed_count

   int                  sender_idle_pct = 0;
   int                  recv_stall_pct = 0;
   int unsigned         cycle_count = 0;
   allocation_tracker   tracker = new();

   contiguous_extent_allocator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) tracker.check_response(rsp_tdata);
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // valid stays up between back-to-back items, it only drops on an idle cycle
   task send_item(logic cmd, logic [FileIdW-1:0] id, logic [StartW-1:0] first,
                  logic [CountW-1:0] len);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {3'b000, len, first, id};
      do @(posedge clock); while (!req_tready);
      tracker.note_request(cmd, id, first, len);
   endtask

   task send_random_item(int create_pct);
      logic               cmd;
      logic [FileIdW-1:0] id;
      logic [StartW-1:0]  first;
      logic [CountW-1:0]  len;
      int                 roll;
      int                 free_block;
      roll = $urandom_range(0, 99);
      first = 6'($urandom_range(0, 63));
      len = 7'($urandom_range(0, 64));
      id = 8'($urandom_range(0, 255));
      if (roll < create_pct) begin
         cmd = CMD_CREATE;
         if ($urandom_range(0, 99) < 85) id = 8'($urandom_range(0, 23));
         free_block = tracker.random_free_block();
         if (free_block >= 0 && $urandom_range(0, 99) < 50) first = 6'(free_block);
         roll = $urandom_range(0, 99);
         if (roll < 60) len = 7'($urandom_range(0, 4));
         else if (roll < 85) len = 7'($urandom_range(0, 16));
         else if (roll < 95) len = 7'($urandom_range(0, 64));
         else len = 7'(64 - int'(first));
      end else if (roll < 92 && tracker.live_files() > 0) begin
         cmd = CMD_DELETE;
         id = tracker.random_live_id();
      end else begin
         // noise: random ids on either command, and unused fields on deletes
         cmd = ($urandom_range(0, 1) == 0) ? CMD_CREATE : CMD_DELETE;
      end
      send_item(cmd, id, first, len);
   endtask

   initial begin
      int create_pct;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      send_item(CMD_DELETE, 8'd7, 6'd0, 7'd0);
      send_item(CMD_CREATE, 8'd0, 6'd0, 7'd0);
      send_item(CMD_CREATE, 8'd255, 6'd63, 7'd1);
      send_item(CMD_CREATE, 8'd0, 6'd5, 7'd1);
      send_item(CMD_CREATE, 8'd1, 6'd60, 7'd4);
      send_item(CMD_CREATE, 8'd2, 6'd63, 7'd2);
      send_item(CMD_CREATE, 8'd2, 6'd1, 7'd64);
      send_item(CMD_DELETE, 8'd255, 6'd42, 7'd21);
      send_item(CMD_CREATE, 8'd170, 6'd0, 7'd64);
      send_item(CMD_DELETE, 8'd170, 6'd0, 7'd0);
      for (int k = 1; k < DefDirEntries; k++)
         send_item(CMD_CREATE, 8'(16 + k), 6'(4 * k), 7'd3);
      // full directory wins over out of range, duplicate wins over full
      send_item(CMD_CREATE, 8'h55, 6'd63, 7'd64);
      send_item(CMD_CREATE, 8'd0, 6'd10, 7'd1);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin sender_idle_pct = 6; recv_stall_pct = 6; end
         endcase
         create_pct = 50;
         for (int n = 0; n < RandomPerPhase; n++) begin
            if (n % 50 == 0) create_pct = $urandom_range(35, 75);
            send_random_item(create_pct);
         end
      end
      req_tvalid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (tracker.errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
